// File: design/tcptt_pkg.sv
`timescale 1ns / 1ps
package tcptt_pkg;

  localparam int unsigned TableEntries = 64;
  localparam int unsigned IdxW = (TableEntries > 1) ? $clog2(TableEntries) : 1;
  localparam int unsigned GrpSize = 8;
  localparam int unsigned NumGrp = (TableEntries + GrpSize - 1) / GrpSize;
  localparam int unsigned CfgIdxW = 2;

  typedef enum logic [1:0] {
    OP_VERDICT = 2'd0,
    OP_INSERT  = 2'd1,
    OP_INS_DATA = 2'd2,
    OP_PROXY   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NOMATCH = 2'd1,
    ST_ILLEGAL = 2'd2,
    ST_FULL    = 2'd3
  } status_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_HTTP = 2'd0,
    CFG_FTP  = 2'd1,
    CFG_SMTP = 2'd2,
    CFG_NONE = 2'd3
  } cfg_idx_e;

  // TCP states
  localparam logic [3:0] TS_CLOSED = 4'd0;
  localparam logic [3:0] TS_LISTEN = 4'd1;
  localparam logic [3:0] TS_SYN_SENT = 4'd2;
  localparam logic [3:0] TS_SYN_RCVD = 4'd3;
  localparam logic [3:0] TS_EST = 4'd4;
  localparam logic [3:0] TS_FW1 = 4'd5;
  localparam logic [3:0] TS_FW2 = 4'd6;
  localparam logic [3:0] TS_CLOSE_WAIT = 4'd7;
  localparam logic [3:0] TS_LAST_ACK = 4'd8;
  localparam logic [3:0] TS_TIME_WAIT = 4'd9;
  localparam logic [3:0] TS_FW1_S = 4'd10;
  localparam logic [3:0] TS_FW2_S = 4'd11;
  localparam logic [3:0] TS_CLOSE_WAIT_S = 4'd12;
  localparam logic [3:0] TS_LAST_ACK_S = 4'd13;
  localparam logic [3:0] TS_TIME_WAIT_S = 4'd14;

  // flag patterns: {fin, ack, syn}
  localparam logic [2:0] PAT_SYN = 3'd1;
  localparam logic [2:0] PAT_ACK = 3'd2;
  localparam logic [2:0] PAT_SYNACK = 3'd3;
  localparam logic [2:0] PAT_FINACK = 3'd6;

  // step outcome codes
  localparam logic [1:0] STEP_ILLEGAL = 2'd0;
  localparam logic [1:0] STEP_OK = 2'd1;
  localparam logic [1:0] STEP_CLOSE = 2'd2;

  typedef struct packed {
    logic [1:0]  operation;
    logic [31:0] src_ip;
    logic [31:0] dst_ip;
    logic [15:0] src_l4_port;
    logic [15:0] dst_l4_port;
    logic        direction;
    logic        syn;
    logic        ack;
    logic        fin;
    logic        rst_req;
    logic [15:0] redir_l4_port;
  } req_t;

  typedef struct packed {
    logic       accept;
    logic [1:0] status;
  } rsp_t;

  typedef struct packed {
    logic load;
    logic match;
    logic sel1;
    logic sel2;
    logic update;
  } cmd_t;

  typedef struct packed {
    logic is_insert;
  } sts_t;

  typedef struct packed {
    logic [1:0] code;
    logic [3:0] snd;
    logic [3:0] rcv;
  } step_t;

  function automatic step_t step_states(logic [3:0] s, logic [3:0] r, logic [2:0] pat);
    step_t o;
    o.code = STEP_ILLEGAL;
    o.snd = s;
    o.rcv = r;
    if (s == TS_CLOSED && r == TS_LISTEN) begin
      if (pat == PAT_SYN) begin
        o.snd = TS_SYN_SENT; o.rcv = TS_SYN_RCVD; o.code = STEP_OK;
      end
    end else if (s == TS_SYN_SENT && r == TS_SYN_RCVD) begin
      if (pat == PAT_SYN) o.code = STEP_OK;
    end else if (s == TS_SYN_RCVD && r == TS_SYN_SENT) begin
      if (pat == PAT_SYNACK) begin
        o.rcv = TS_EST; o.code = STEP_OK;
      end
    end else if (s == TS_SYN_RCVD && r == TS_EST) begin
      if (pat == PAT_SYNACK) o.code = STEP_OK;
      else if (pat == PAT_FINACK) begin
        o.snd = TS_FW1; o.code = STEP_OK;
      end
    end else if (s == TS_EST && r == TS_SYN_RCVD) begin
      if (pat == PAT_ACK) begin
        o.rcv = TS_EST; o.code = STEP_OK;
      end
    end else if (s == TS_EST && r == TS_EST) begin
      if (pat == PAT_ACK) o.code = STEP_OK;
      else if (pat == PAT_FINACK) begin
        o.snd = TS_FW1; o.code = STEP_OK;
      end
    end else if (s == TS_FW1 && r == TS_EST) begin
      if (pat == PAT_FINACK) o.code = STEP_OK;
    end else if (s == TS_EST && r == TS_FW1) begin
      if (pat == PAT_FINACK) begin
        o.snd = TS_LAST_ACK; o.rcv = TS_TIME_WAIT; o.code = STEP_OK;
      end else if (pat == PAT_ACK) begin
        o.snd = TS_CLOSE_WAIT; o.rcv = TS_FW2; o.code = STEP_OK;
      end
    end else if (s == TS_TIME_WAIT && r == TS_LAST_ACK) begin
      if (pat == PAT_ACK) begin
        o.snd = TS_CLOSED; o.rcv = TS_CLOSED; o.code = STEP_OK;
      end
    end else if (s == TS_CLOSE_WAIT && r == TS_FW2) begin
      if (pat == PAT_FINACK) begin
        o.snd = TS_CLOSED; o.rcv = TS_CLOSED; o.code = STEP_OK;
      end
    end else if (s == TS_CLOSED && r == TS_CLOSED) begin
      if (pat == PAT_FINACK) begin
        o.snd = TS_FW1_S; o.code = STEP_OK;
      end
    end else if (s == TS_FW1_S && r == TS_CLOSED) begin
      if (pat == PAT_FINACK) o.code = STEP_OK;
    end else if (s == TS_CLOSED && r == TS_FW1_S) begin
      if (pat == PAT_FINACK) begin
        o.snd = TS_LAST_ACK_S; o.rcv = TS_TIME_WAIT_S; o.code = STEP_OK;
      end else if (pat == PAT_ACK) begin
        o.snd = TS_CLOSE_WAIT_S; o.rcv = TS_FW2_S; o.code = STEP_OK;
      end
    end else if (s == TS_TIME_WAIT_S && r == TS_LAST_ACK_S) begin
      if (pat == PAT_ACK) o.code = STEP_CLOSE;
    end else if (s == TS_CLOSE_WAIT_S && r == TS_FW2_S) begin
      if (pat == PAT_FINACK) o.code = STEP_CLOSE;
    end
    return o;
  endfunction

endpackage

// File: design/tcptt_ctrl.sv
`timescale 1ns / 1ps
module tcptt_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  tcptt_pkg::sts_t sts_i,
  output tcptt_pkg::cmd_t cmd_o,
  output logic            busy_o,
  output logic            done_o
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_MATCH = 5'b00010,
    S_SEL1  = 5'b00100,
    S_SEL2  = 5'b01000,
    S_UPD   = 5'b10000
  } state_e;

  state_e state_q, state_d;
  logic   done_q;

  always_comb begin
    state_d = state_q;
    cmd_o = '0;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d = S_MATCH;
        end
      end
      S_MATCH: begin
        // inserts need no search
        if (sts_i.is_insert) begin
          state_d = S_UPD;
        end else begin
          cmd_o.match = 1'b1;
          state_d = S_SEL1;
        end
      end
      S_SEL1: begin
        cmd_o.sel1 = 1'b1;
        state_d = S_SEL2;
      end
      S_SEL2: begin
        cmd_o.sel2 = 1'b1;
        state_d = S_UPD;
      end
      S_UPD: begin
        cmd_o.update = 1'b1;
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      done_q <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q <= cmd_o.update;
    end
  end

  assign busy_o = (state_q != S_IDLE);
  assign done_o = done_q;

endmodule

// File: design/tcptt_dp.sv
`timescale 1ns / 1ps
module tcptt_dp (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  tcptt_pkg::cmd_t                  cmd_i,
  output tcptt_pkg::sts_t                  sts_o,
  input  tcptt_pkg::req_t                  req_i,
  input  logic                             cfg_we_i,
  input  logic [tcptt_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [15:0]                      cfg_data_i,
  output tcptt_pkg::rsp_t                  rsp_o
);

  localparam int unsigned N = tcptt_pkg::TableEntries;
  localparam int unsigned IW = tcptt_pkg::IdxW;
  localparam int unsigned G = tcptt_pkg::NumGrp;
  localparam int unsigned GS = tcptt_pkg::GrpSize;

  logic [15:0] http_q, ftp_q, smtp_q;
  tcptt_pkg::req_t req_q;
  tcptt_pkg::rsp_t rsp_q;
  tcptt_pkg::rsp_t rsp_q_d;

  // per-entry registers
  logic [N-1:0]  valid_q, valid_d;
  logic [31:0]   caddr_q [N];
  logic [15:0]   cport_q [N], cport_d [N];
  logic [3:0]    cst_q [N], cst_d [N];
  logic [31:0]   saddr_q [N];
  logic [15:0]   sport_q [N];
  logic [3:0]    sst_q [N], sst_d [N];
  logic [15:0]   redir_q [N], redir_d [N];
  logic [N-1:0]  opener_q, opener_d;
  logic [IW-1:0] stamp_q [N], stamp_d [N];
  logic [N-1:0]  ins_lane;

  // search pipeline
  logic [N-1:0]  hit_d, hit_q, dc_d, dc_q, sndc_d, sndc_q;
  logic [G-1:0]  gfound_d, gfound_q;
  logic [IW-1:0] gstamp_d [G], gstamp_q [G];
  logic [IW-1:0] gidx_d [G], gidx_q [G];
  logic          found_d, found_q;
  logic [IW-1:0] sel_idx_d, sel_idx_q;

  logic svc_src, svc_dst;
  logic [2:0] pat;

  assign svc_src = (req_q.src_l4_port == http_q) || (req_q.src_l4_port == ftp_q) ||
                   (req_q.src_l4_port == smtp_q);
  assign svc_dst = (req_q.dst_l4_port == http_q) || (req_q.dst_l4_port == ftp_q) ||
                   (req_q.dst_l4_port == smtp_q);
  assign pat = {req_q.fin, req_q.ack, req_q.syn};
  assign sts_o.is_insert = (req_q.operation == tcptt_pkg::OP_INSERT) ||
                           (req_q.operation == tcptt_pkg::OP_INS_DATA);

  // per-lane match
  always_comb begin
    logic sc, m, exact;
    logic [31:0] s_ip, r_ip;
    logic [15:0] s_pt, r_pt;
    for (int e = 0; e < N; e++) begin
      sc = (opener_q[e] == req_q.direction);
      s_ip = sc ? caddr_q[e] : saddr_q[e];
      r_ip = sc ? saddr_q[e] : caddr_q[e];
      s_pt = sc ? cport_q[e] : sport_q[e];
      r_pt = sc ? sport_q[e] : cport_q[e];
      dc_d[e] = (cport_q[e] == 16'd0) && (req_q.dst_l4_port == sport_q[e]) &&
                (req_q.src_ip == caddr_q[e]) && (req_q.dst_ip == saddr_q[e]);
      m = (s_ip == req_q.src_ip) && (r_ip == req_q.dst_ip) &&
          ((svc_src && redir_q[e] == req_q.dst_l4_port && s_pt == req_q.src_l4_port) ||
           (svc_dst && redir_q[e] == req_q.src_l4_port && r_pt == req_q.dst_l4_port) ||
           (s_pt == req_q.src_l4_port && r_pt == req_q.dst_l4_port));
      exact = (caddr_q[e] == req_q.src_ip) && (cport_q[e] == req_q.src_l4_port) &&
              (saddr_q[e] == req_q.dst_ip) && (sport_q[e] == req_q.dst_l4_port);
      hit_d[e] = valid_q[e] &&
                 ((req_q.operation == tcptt_pkg::OP_VERDICT) ? (dc_d[e] || m) : exact);
      sndc_d[e] = dc_d[e] || sc;
    end
  end

  // newest hit per group of entries
  always_comb begin
    int unsigned idx;
    for (int g = 0; g < G; g++) begin
      gfound_d[g] = 1'b0;
      gstamp_d[g] = '0;
      gidx_d[g] = '0;
      for (int k = 0; k < GS; k++) begin
        idx = g * GS + k;
        if (idx < N) begin
          if (hit_q[idx] && (!gfound_d[g] || stamp_q[idx] < gstamp_d[g])) begin
            gfound_d[g] = 1'b1;
            gstamp_d[g] = stamp_q[idx];
            gidx_d[g] = IW'(idx);
          end
        end
      end
    end
  end

  // newest hit across groups
  always_comb begin
    logic [IW-1:0] best;
    best = '0;
    found_d = 1'b0;
    sel_idx_d = '0;
    for (int g = 0; g < G; g++) begin
      if (gfound_q[g] && (!found_d || gstamp_q[g] < best)) begin
        found_d = 1'b1;
        best = gstamp_q[g];
        sel_idx_d = gidx_q[g];
      end
    end
  end

  // table update
  always_comb begin
    logic [N-1:0] sel_oh;
    tcptt_pkg::step_t stp [N];
    tcptt_pkg::step_t stp_sel;
    logic [IW-1:0] st_sel;
    logic full, del, got_free;
    logic [IW-1:0] free_idx;
    tcptt_pkg::rsp_t rsp;

    for (int e = 0; e < N; e++) begin
      sel_oh[e] = found_q && (sel_idx_q == IW'(e));
      stp[e] = tcptt_pkg::step_states(sndc_q[e] ? cst_q[e] : sst_q[e],
                                      sndc_q[e] ? sst_q[e] : cst_q[e], pat);
    end
    stp_sel = '0;
    st_sel = '0;
    for (int e = 0; e < N; e++) begin
      if (sel_oh[e]) begin
        stp_sel = stp_sel | stp[e];
        st_sel = st_sel | stamp_q[e];
      end
    end
    full = &valid_q;
    got_free = 1'b0;
    free_idx = '0;
    for (int e = N - 1; e >= 0; e--) begin
      if (!valid_q[e]) begin
        got_free = 1'b1;
        free_idx = IW'(e);
      end
    end

    valid_d = valid_q;
    opener_d = opener_q;
    ins_lane = '0;
    for (int e = 0; e < N; e++) begin
      cport_d[e] = cport_q[e];
      cst_d[e] = cst_q[e];
      sst_d[e] = sst_q[e];
      redir_d[e] = redir_q[e];
      stamp_d[e] = stamp_q[e];
    end
    del = 1'b0;
    rsp.accept = 1'b0;
    rsp.status = tcptt_pkg::ST_NOMATCH;

    case (tcptt_pkg::op_e'(req_q.operation))
      tcptt_pkg::OP_VERDICT: begin
        if (found_q) begin
          for (int e = 0; e < N; e++) begin
            if (sel_oh[e] && dc_q[e]) begin
              cport_d[e] = req_q.src_l4_port;
              opener_d[e] = req_q.direction;
            end
          end
          if (req_q.rst_req) begin
            del = 1'b1;
            rsp.accept = 1'b1;
            rsp.status = tcptt_pkg::ST_OK;
          end else if (stp_sel.code == tcptt_pkg::STEP_ILLEGAL) begin
            rsp.status = tcptt_pkg::ST_ILLEGAL;
          end else begin
            rsp.accept = 1'b1;
            rsp.status = tcptt_pkg::ST_OK;
            del = (stp_sel.code == tcptt_pkg::STEP_CLOSE);
            for (int e = 0; e < N; e++) begin
              if (sel_oh[e]) begin
                cst_d[e] = sndc_q[e] ? stp[e].snd : stp[e].rcv;
                sst_d[e] = sndc_q[e] ? stp[e].rcv : stp[e].snd;
              end
            end
          end
        end
        if (del) begin
          for (int e = 0; e < N; e++) begin
            if (sel_oh[e]) valid_d[e] = 1'b0;
            else if (valid_q[e] && stamp_q[e] > st_sel) stamp_d[e] = stamp_q[e] - IW'(1);
          end
        end
      end
      tcptt_pkg::OP_INSERT, tcptt_pkg::OP_INS_DATA: begin
        if (full || !got_free) begin
          rsp.status = tcptt_pkg::ST_FULL;
        end else begin
          rsp.accept = 1'b1;
          rsp.status = tcptt_pkg::ST_OK;
          for (int e = 0; e < N; e++) begin
            if (free_idx == IW'(e)) begin
              ins_lane[e] = 1'b1;
              valid_d[e] = 1'b1;
              stamp_d[e] = '0;
              redir_d[e] = '0;
              if (req_q.operation == tcptt_pkg::OP_INSERT) begin
                cport_d[e] = req_q.src_l4_port;
                cst_d[e] = tcptt_pkg::TS_SYN_SENT;
                sst_d[e] = tcptt_pkg::TS_SYN_RCVD;
                opener_d[e] = req_q.direction;
              end else begin
                cport_d[e] = '0;
                cst_d[e] = tcptt_pkg::TS_CLOSED;
                sst_d[e] = tcptt_pkg::TS_LISTEN;
                opener_d[e] = 1'b0;
              end
            end else if (valid_q[e]) begin
              stamp_d[e] = stamp_q[e] + IW'(1);
            end
          end
        end
      end
      tcptt_pkg::OP_PROXY: begin
        if (found_q) begin
          rsp.accept = 1'b1;
          rsp.status = tcptt_pkg::ST_OK;
          for (int e = 0; e < N; e++) begin
            if (sel_oh[e]) redir_d[e] = req_q.redir_l4_port;
          end
        end
      end
      default: ;
    endcase
    rsp_o = rsp_q;
    rsp_q_d = rsp;
  end

  // control and configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      http_q <= 16'd80;
      ftp_q <= 16'd21;
      smtp_q <= 16'd25;
      valid_q <= '0;
      hit_q <= '0;
      gfound_q <= '0;
      found_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (tcptt_pkg::cfg_idx_e'(cfg_index_i))
          tcptt_pkg::CFG_HTTP: http_q <= cfg_data_i;
          tcptt_pkg::CFG_FTP:  ftp_q <= cfg_data_i;
          tcptt_pkg::CFG_SMTP: smtp_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (cmd_i.update) valid_q <= valid_d;
      if (cmd_i.load) begin
        hit_q <= '0;
        found_q <= 1'b0;
      end
      if (cmd_i.match) hit_q <= hit_d;
      if (cmd_i.sel1) gfound_q <= gfound_d;
      if (cmd_i.sel2) found_q <= found_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) req_q <= req_i;
    if (cmd_i.match) begin
      dc_q <= dc_d;
      sndc_q <= sndc_d;
    end
    if (cmd_i.sel1) begin
      gstamp_q <= gstamp_d;
      gidx_q <= gidx_d;
    end
    if (cmd_i.sel2) sel_idx_q <= sel_idx_d;
    if (cmd_i.update) begin
      rsp_q <= rsp_q_d;
      opener_q <= opener_d;
      for (int e = 0; e < N; e++) begin
        cport_q[e] <= cport_d[e];
        cst_q[e] <= cst_d[e];
        sst_q[e] <= sst_d[e];
        redir_q[e] <= redir_d[e];
        stamp_q[e] <= stamp_d[e];
        if (ins_lane[e]) begin
          caddr_q[e] <= req_q.src_ip;
          saddr_q[e] <= req_q.dst_ip;
          sport_q[e] <= req_q.dst_l4_port;
        end
      end
    end
  end

endmodule

// File: design/tcp_connection_tracking_table_top.sv
`timescale 1ns / 1ps
// Channel   Direction  Handshake                     Payload
// request   in         start_i, busy_o               req_i  (tcptt_pkg::req_t)
// result    out        done_o (one-cycle strobe)     rsp_o  (tcptt_pkg::rsp_t)
// config    in         cfg_valid_i, cfg_ready_o      cfg_index_i, cfg_data_i
//
// A request transfers when start_i is high and busy_o is low. Lookups (verdict,
// proxy set) pass through match, two stages of the newest-first select tree,
// then the table update before their result is shown. Inserts skip the search
// and go straight to the table update.
// The next request may transfer in the cycle the result is shown.
// Reset empties the table at once and restores the service ports.
// The receiver cannot stall: done_o marks each result for one cycle only.
module tcp_connection_tracking_table_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  output logic                          busy_o,
  input  tcptt_pkg::req_t               req_i,
  output logic                          done_o,
  output tcptt_pkg::rsp_t               rsp_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [tcptt_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [15:0]                   cfg_data_i
);

  tcptt_pkg::cmd_t cmd;
  tcptt_pkg::sts_t sts;
  logic            busy;

  // configuration is always taken
  assign cfg_ready_o = 1'b1;
  assign busy_o = busy;

  tcptt_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i && !busy),
    .sts_i   (sts),
    .cmd_o   (cmd),
    .busy_o  (busy),
    .done_o  (done_o)
  );

  tcptt_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .req_i       (req_i),
    .cfg_we_i    (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .rsp_o       (rsp_o)
  );

endmodule

// File: sim/tcp_connection_tracking_table_top_test.sv
`timescale 1ns / 1ps
module tcp_connection_tracking_table_top_test;
  import tcptt_pkg::*;

  // Stimulus entries: a request, a register write, or a drain that holds the
  // sender until every expected result is back and the block has settled.
  typedef enum logic [1:0] {
    K_REQ,
    K_CFG,
    K_DRAIN
  } stim_kind_e;

  typedef struct {
    stim_kind_e kind;
    req_t       req;
    cfg_idx_e   cidx;
    logic [15:0] cdata;
    bit         calm;
  } stim_t;

  typedef struct packed {
    logic [1:0] code;
    logic [3:0] snd;
    logic [3:0] rcv;
  } conn_step_t;

  localparam int unsigned WatchLimit = 3000;
  localparam int unsigned SettleCycles = 8;
  localparam int unsigned ItemGoal = 700;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start_i = 1'b0;
  logic busy_o;
  req_t req_i = '0;
  logic done_o;
  rsp_t rsp_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i = CFG_NONE;
  logic [15:0] cfg_data_i = '0;

  tcp_connection_tracking_table_top i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .busy_o      (busy_o),
    .req_i       (req_i),
    .done_o      (done_o),
    .rsp_o       (rsp_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Shadow of the connection table. age_q lists occupied slots, newest first,
  // which is exactly the order every search walks.
  // ---------------------------------------------------------------------------
  logic [15:0] svc_http = 16'd80;
  logic [15:0] svc_ftp = 16'd21;
  logic [15:0] svc_smtp = 16'd25;
  bit          used [TableEntries];
  logic [31:0] cl_ip [TableEntries];
  logic [15:0] cl_port [TableEntries];
  logic [3:0]  cl_st [TableEntries];
  logic [31:0] sv_ip [TableEntries];
  logic [15:0] sv_port [TableEntries];
  logic [3:0]  sv_st [TableEntries];
  logic [15:0] redir [TableEntries];
  logic        opener [TableEntries];
  int          age_q[$];

  rsp_t  expected_q[$];
  stim_t stim_q[$];

  int n_verdict, n_insert, n_proxy, n_cfg, n_checked, n_fail, n_accepted, n_full;

  function automatic bit is_service_port(logic [15:0] p);
    return p == svc_http || p == svc_ftp || p == svc_smtp;
  endfunction

  // Advance the sender/receiver state pair for one flag pattern.
  function automatic conn_step_t conn_advance(logic [3:0] s, logic [3:0] r, logic [2:0] pat);
    conn_step_t o;
    o = '{code: STEP_ILLEGAL, snd: s, rcv: r};
    case ({s, r})
      {TS_CLOSED, TS_LISTEN}: begin
        if (pat == PAT_SYN) o = '{STEP_OK, TS_SYN_SENT, TS_SYN_RCVD};
      end
      {TS_SYN_SENT, TS_SYN_RCVD}: begin
        if (pat == PAT_SYN) o.code = STEP_OK;
      end
      {TS_SYN_RCVD, TS_SYN_SENT}: begin
        if (pat == PAT_SYNACK) o = '{STEP_OK, s, TS_EST};
      end
      {TS_SYN_RCVD, TS_EST}: begin
        if (pat == PAT_SYNACK) o.code = STEP_OK;
        else if (pat == PAT_FINACK) o = '{STEP_OK, TS_FW1, r};
      end
      {TS_EST, TS_SYN_RCVD}: begin
        if (pat == PAT_ACK) o = '{STEP_OK, s, TS_EST};
      end
      {TS_EST, TS_EST}: begin
        if (pat == PAT_ACK) o.code = STEP_OK;
        else if (pat == PAT_FINACK) o = '{STEP_OK, TS_FW1, r};
      end
      {TS_FW1, TS_EST}: begin
        if (pat == PAT_FINACK) o.code = STEP_OK;
      end
      {TS_EST, TS_FW1}: begin
        if (pat == PAT_FINACK) o = '{STEP_OK, TS_LAST_ACK, TS_TIME_WAIT};
        else if (pat == PAT_ACK) o = '{STEP_OK, TS_CLOSE_WAIT, TS_FW2};
      end
      {TS_TIME_WAIT, TS_LAST_ACK}: begin
        if (pat == PAT_ACK) o = '{STEP_OK, TS_CLOSED, TS_CLOSED};
      end
      {TS_CLOSE_WAIT, TS_FW2}: begin
        if (pat == PAT_FINACK) o = '{STEP_OK, TS_CLOSED, TS_CLOSED};
      end
      {TS_CLOSED, TS_CLOSED}: begin
        if (pat == PAT_FINACK) o = '{STEP_OK, TS_FW1_S, r};
      end
      {TS_FW1_S, TS_CLOSED}: begin
        if (pat == PAT_FINACK) o.code = STEP_OK;
      end
      {TS_CLOSED, TS_FW1_S}: begin
        if (pat == PAT_FINACK) o = '{STEP_OK, TS_LAST_ACK_S, TS_TIME_WAIT_S};
        else if (pat == PAT_ACK) o = '{STEP_OK, TS_CLOSE_WAIT_S, TS_FW2_S};
      end
      {TS_TIME_WAIT_S, TS_LAST_ACK_S}: begin
        if (pat == PAT_ACK) o.code = STEP_CLOSE;
      end
      {TS_CLOSE_WAIT_S, TS_FW2_S}: begin
        if (pat == PAT_FINACK) o.code = STEP_CLOSE;
      end
      default: ;
    endcase
    return o;
  endfunction

  // Free a slot; every younger entry keeps its relative age.
  function automatic void drop_connection(int e);
    int pos;
    pos = -1;
    used[e] = 1'b0;
    foreach (age_q[k]) if (age_q[k] == e) pos = k;
    if (pos >= 0) age_q.delete(pos);
  endfunction

  // Apply one accepted request to the shadow table and return its verdict.
  function automatic rsp_t predict_table(req_t r);
    rsp_t o;
    int hit, e, slot;
    bit sc, m;
    logic [31:0] s_ip, r_ip;
    logic [15:0] s_pt, r_pt;
    conn_step_t st;
    o.accept = 1'b0;
    o.status = ST_NOMATCH;
    hit = -1;
    sc = 1'b1;
    slot = -1;
    case (op_e'(r.operation))
      OP_VERDICT: begin
        n_verdict++;
        foreach (age_q[k]) begin
          e = age_q[k];
          // client port still unknown: first packet of an FTP data connection
          if (cl_port[e] == 16'd0 && r.dst_l4_port == sv_port[e] &&
              r.src_ip == cl_ip[e] && r.dst_ip == sv_ip[e]) begin
            opener[e] = r.direction;
            cl_port[e] = r.src_l4_port;
            sc = 1'b1;
            hit = e;
            break;
          end
          sc = (opener[e] == r.direction);
          s_ip = sc ? cl_ip[e] : sv_ip[e];
          r_ip = sc ? sv_ip[e] : cl_ip[e];
          s_pt = sc ? cl_port[e] : sv_port[e];
          r_pt = sc ? sv_port[e] : cl_port[e];
          m = 1'b0;
          if (s_ip == r.src_ip && r_ip == r.dst_ip) begin
            if (is_service_port(r.src_l4_port) && redir[e] == r.dst_l4_port &&
                s_pt == r.src_l4_port) m = 1'b1;
            if (is_service_port(r.dst_l4_port) && redir[e] == r.src_l4_port &&
                r_pt == r.dst_l4_port) m = 1'b1;
            if (s_pt == r.src_l4_port && r_pt == r.dst_l4_port) m = 1'b1;
          end
          if (m) begin
            hit = e;
            break;
          end
        end
        if (hit >= 0) begin
          if (r.rst_req) begin
            drop_connection(hit);
            o = '{1'b1, ST_OK};
          end else begin
            if (sc) st = conn_advance(cl_st[hit], sv_st[hit], {r.fin, r.ack, r.syn});
            else st = conn_advance(sv_st[hit], cl_st[hit], {r.fin, r.ack, r.syn});
            if (st.code == STEP_ILLEGAL) begin
              o.status = ST_ILLEGAL;
            end else begin
              if (sc) begin
                cl_st[hit] = st.snd;
                sv_st[hit] = st.rcv;
              end else begin
                sv_st[hit] = st.snd;
                cl_st[hit] = st.rcv;
              end
              if (st.code == STEP_CLOSE) drop_connection(hit);
              o = '{1'b1, ST_OK};
            end
          end
        end
      end
      OP_INSERT, OP_INS_DATA: begin
        n_insert++;
        for (int i = 0; i < TableEntries; i++) begin
          if (!used[i] && slot < 0) slot = i;
        end
        if (slot < 0) begin
          o.status = ST_FULL;
          n_full++;
        end else begin
          used[slot] = 1'b1;
          age_q.push_front(slot);
          cl_ip[slot] = r.src_ip;
          sv_ip[slot] = r.dst_ip;
          sv_port[slot] = r.dst_l4_port;
          redir[slot] = '0;
          if (op_e'(r.operation) == OP_INSERT) begin
            cl_port[slot] = r.src_l4_port;
            cl_st[slot] = TS_SYN_SENT;
            sv_st[slot] = TS_SYN_RCVD;
            opener[slot] = r.direction;
          end else begin
            cl_port[slot] = '0;
            cl_st[slot] = TS_CLOSED;
            sv_st[slot] = TS_LISTEN;
            opener[slot] = 1'b0;
          end
          o = '{1'b1, ST_OK};
        end
      end
      default: begin
        n_proxy++;
        foreach (age_q[k]) begin
          e = age_q[k];
          if (cl_ip[e] == r.src_ip && cl_port[e] == r.src_l4_port &&
              sv_ip[e] == r.dst_ip && sv_port[e] == r.dst_l4_port) begin
            redir[e] = r.redir_l4_port;
            o = '{1'b1, ST_OK};
            break;
          end
        end
      end
    endcase
    return o;
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: take the head of stim_q, hold start or the write valid until the
  // transfer, and predict each request at the edge it transfers.
  // ---------------------------------------------------------------------------
  int unsigned settle;

  always @(posedge clk_i or negedge rst_ni) begin
    logic nxt_start;
    logic nxt_cfg;
    stim_t cur;
    if (!rst_ni) begin
      start_i <= 1'b0;
      cfg_valid_i <= 1'b0;
      settle <= 0;
    end else begin
      nxt_start = start_i;
      nxt_cfg = cfg_valid_i;
      if (start_i && !busy_o) begin
        expected_q.push_back(predict_table(req_i));
        nxt_start = 1'b0;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        n_cfg++;
        case (cfg_idx_e'(cfg_index_i))
          CFG_HTTP: svc_http = cfg_data_i;
          CFG_FTP:  svc_ftp = cfg_data_i;
          CFG_SMTP: svc_smtp = cfg_data_i;
          default: ;
        endcase
        nxt_cfg = 1'b0;
      end
      if (!nxt_start && !nxt_cfg && stim_q.size() > 0) begin
        cur = stim_q[0];
        case (cur.kind)
          K_REQ: begin
            if (cur.calm || $urandom_range(99) >= 38) begin
              req_i <= cur.req;
              nxt_start = 1'b1;
              void'(stim_q.pop_front());
            end
          end
          K_CFG: begin
            if (cur.calm || $urandom_range(99) >= 38) begin
              cfg_index_i <= cur.cidx;
              cfg_data_i <= cur.cdata;
              nxt_cfg = 1'b1;
              void'(stim_q.pop_front());
            end
          end
          default: begin
            // hold until the table is quiet, then let it settle
            if (expected_q.size() == 0 && !busy_o) begin
              if (settle >= SettleCycles) begin
                settle <= 0;
                void'(stim_q.pop_front());
              end else begin
                settle <= settle + 1;
              end
            end else begin
              settle <= 0;
            end
          end
        endcase
      end
      start_i <= nxt_start;
      cfg_valid_i <= nxt_cfg;
    end
  end

  // Monitor: every strobed result must match the oldest outstanding verdict.
  always @(posedge clk_i) begin
    rsp_t exp_rsp;
    if (rst_ni && done_o) begin
      if (expected_q.size() == 0) begin
        n_fail++;
        if (n_fail <= 10) $display("result with nothing outstanding: accept=%0b status=%0d",
                                   rsp_o.accept, rsp_o.status);
      end else begin
        exp_rsp = expected_q.pop_front();
        n_checked++;
        if (rsp_o.accept) n_accepted++;
        if (rsp_o.accept !== exp_rsp.accept || rsp_o.status !== exp_rsp.status) begin
          n_fail++;
          if (n_fail <= 10)
            $display("mismatch on result %0d: expected accept=%0b status=%0d, got accept=%0b status=%0d",
                     n_checked, exp_rsp.accept, exp_rsp.status, rsp_o.accept, rsp_o.status);
        end
      end
    end
  end

  // Watchdog: end the run if nothing transfers for too long.
  int unsigned quiet_cycles;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((start_i && !busy_o) || (cfg_valid_i && cfg_ready_o) || done_o) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= WatchLimit) begin
        $display("tcp_connection_tracking_table_top regression: fail");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end else begin
      quiet_cycles <= 0;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus generation. Service ports are tracked at build time so flows can
  // aim at the proxy paths of whatever configuration is current.
  // ---------------------------------------------------------------------------
  logic [15:0] gen_http = 16'd80;
  logic [15:0] gen_ftp = 16'd21;
  logic [15:0] gen_smtp = 16'd25;
  bit          gen_calm;
  int          n_items;
  logic [31:0] fl_c, fl_s;
  logic [15:0] fl_cp, fl_sp, fl_pp;
  logic        fl_d;
  bit          fl_proxy;

  task automatic push_req(op_e op, logic [31:0] sip, logic [31:0] dip, logic [15:0] sp,
                          logic [15:0] dp, logic dir, logic [3:0] flags, logic [15:0] pp);
    stim_t s;
    s.kind = K_REQ;
    s.req = '{operation: op, src_ip: sip, dst_ip: dip, src_l4_port: sp, dst_l4_port: dp,
              direction: dir, syn: flags[0], ack: flags[1], fin: flags[2],
              rst_req: flags[3], redir_l4_port: pp};
    s.calm = gen_calm;
    stim_q.push_back(s);
    n_items++;
  endtask

  task automatic push_drain();
    stim_t s;
    s.kind = K_DRAIN;
    stim_q.push_back(s);
  endtask

  task automatic push_cfg(cfg_idx_e idx, logic [15:0] v);
    stim_t s;
    push_drain();
    s.kind = K_CFG;
    s.cidx = idx;
    s.cdata = v;
    s.calm = gen_calm;
    stim_q.push_back(s);
    case (idx)
      CFG_HTTP: gen_http = v;
      CFG_FTP:  gen_ftp = v;
      CFG_SMTP: gen_smtp = v;
      default: ;
    endcase
  endtask

  function automatic logic [31:0] pick_ip();
    case ($urandom_range(5))
      0: return 32'hFFFF_FFFF;
      1: return 32'h0;
      2, 3: return 32'h0A00_0000 | $urandom_range(3);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [15:0] pick_service();
    case ($urandom_range(4))
      0: return gen_http;
      1: return gen_ftp;
      2: return gen_smtp;
      3: return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  // One packet of the current flow; flags are {rst, fin, ack, syn}.
  task automatic pkt(bit from_client, logic [3:0] flags);
    logic [15:0] cport;
    cport = fl_cp;
    if (fl_proxy && $urandom_range(1)) cport = fl_pp;
    if (from_client) push_req(OP_VERDICT, fl_c, fl_s, cport, fl_sp, fl_d, flags, 16'($urandom));
    else push_req(OP_VERDICT, fl_s, fl_c, fl_sp, cport, ~fl_d, flags, 16'($urandom));
  endtask

  // Handshake, data and the two-phase close, with optional noise and aborts.
  task automatic flow_body(bit noisy, bit [1:0] path);
    bit x, y;
    pkt(1'b0, 4'b0011);
    pkt(1'b1, 4'b0010);
    repeat ($urandom_range(3)) pkt(1'($urandom_range(1)), 4'b0010);
    if (noisy && $urandom_range(99) < 20) pkt(1'($urandom_range(1)), 4'($urandom_range(7)));
    if (noisy && $urandom_range(99) < 10) begin
      pkt(1'($urandom_range(1)), 4'b1000 | 4'($urandom_range(7)));
      return;
    end
    if (noisy && $urandom_range(99) < 5) return;
    x = 1'($urandom_range(1));
    pkt(x, 4'b0110);
    if (path[0]) begin
      pkt(!x, 4'b0010);
      pkt(!x, 4'b0110);
    end else begin
      pkt(!x, 4'b0110);
      pkt(x, 4'b0010);
    end
    if (noisy && $urandom_range(99) < 15) pkt(1'($urandom_range(1)), 4'($urandom_range(7)));
    y = 1'($urandom_range(1));
    pkt(y, 4'b0110);
    if (path[1]) begin
      pkt(!y, 4'b0010);
      pkt(!y, 4'b0110);
    end else begin
      pkt(!y, 4'b0110);
      pkt(y, 4'b0010);
    end
  endtask

  task automatic conn_flow(bit noisy, bit [1:0] path);
    fl_c = pick_ip();
    fl_s = pick_ip();
    fl_cp = $urandom_range(99) < 3 ? 16'hFFFF : 16'($urandom_range(1024, 65535));
    fl_sp = pick_service();
    fl_d = 1'($urandom_range(1));
    fl_proxy = 1'b0;
    push_req(OP_INSERT, fl_c, fl_s, fl_cp, fl_sp, fl_d, 4'($urandom_range(15)),
             16'($urandom));
    if ($urandom_range(99) < 30) pkt(1'b1, 4'b0001);
    if ($urandom_range(99) < 30) begin
      fl_pp = 16'($urandom);
      push_req(OP_PROXY, fl_c, fl_s, fl_cp, fl_sp, 1'($urandom_range(1)),
               4'($urandom_range(15)), fl_pp);
      fl_proxy = 1'b1;
    end
    flow_body(noisy, path);
  endtask

  // FTP data connection: inserted with no client port, opened by a SYN.
  task automatic data_flow(bit noisy, bit [1:0] path);
    fl_c = pick_ip();
    fl_s = pick_ip();
    fl_sp = $urandom_range(99) < 20 ? 16'd0 : 16'($urandom);
    fl_cp = 16'($urandom);
    fl_d = 1'($urandom_range(1));
    fl_proxy = 1'b0;
    push_req(OP_INS_DATA, fl_c, fl_s, 16'($urandom), fl_sp, 1'($urandom_range(1)),
             4'($urandom_range(15)), 16'($urandom));
    pkt(1'b1, 4'b0001);
    flow_body(noisy, path);
  endtask

  initial begin
    int phase_goal;
    logic [15:0] rnd_port;
    // directed: empty table, a clean connection through both close paths,
    // a data connection and a reset
    push_drain();
    push_req(OP_VERDICT, '0, '0, '0, '0, 1'b0, 4'b0000, '0);
    push_req(OP_PROXY, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 1'b1, 4'b1111,
             16'hFFFF);
    fl_c = 32'hFFFF_FFFF;
    fl_s = 32'h0;
    fl_cp = 16'hFFFF;
    fl_sp = 16'd80;
    fl_d = 1'b1;
    fl_pp = 16'hFFFF;
    fl_proxy = 1'b1;
    push_req(OP_INSERT, fl_c, fl_s, fl_cp, fl_sp, fl_d, 4'b0000, 16'h0);
    push_req(OP_PROXY, fl_c, fl_s, fl_cp, fl_sp, 1'b0, 4'b0000, fl_pp);
    pkt(1'b1, 4'b0111);
    flow_body(1'b0, 2'b01);
    data_flow(1'b0, 2'b10);
    push_req(OP_VERDICT, fl_c, fl_s, fl_cp, fl_sp, fl_d, 4'b1000, '0);

    // random phases, each under a different set of service ports
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          push_cfg(CFG_HTTP, 16'd80);
          push_cfg(CFG_FTP, 16'd21);
          push_cfg(CFG_SMTP, 16'd25);
        end
        1: begin
          push_cfg(CFG_HTTP, 16'd0);
          push_cfg(CFG_FTP, 16'hFFFF);
          push_cfg(CFG_SMTP, 16'd8080);
          push_cfg(CFG_NONE, 16'h1234);
        end
        2: begin
          push_cfg(CFG_HTTP, 16'hFFFF);
          push_cfg(CFG_FTP, 16'd0);
          push_cfg(CFG_SMTP, 16'hFFFF);
        end
        default: begin
          rnd_port = 16'($urandom);
          push_cfg(CFG_HTTP, rnd_port);
          push_cfg(CFG_FTP, 16'($urandom));
          push_cfg(CFG_SMTP, 16'($urandom));
        end
      endcase
      phase_goal = n_items + ItemGoal / 4;
      // one long stretch with no idling on the sender
      gen_calm = (ph == 1);
      if (ph == 2) begin
        // overfill the table, then tear everything down with resets
        for (int i = 0; i < TableEntries + 2; i++)
          push_req(OP_INSERT, 32'hC000_0000 + i, 32'h5000_0000, 16'(i + 1), 16'd443,
                   1'b0, 4'b0000, '0);
        for (int i = 0; i < TableEntries + 2; i++)
          push_req(OP_VERDICT, 32'hC000_0000 + i, 32'h5000_0000, 16'(i + 1), 16'd443,
                   1'b0, 4'b1000, '0);
      end
      while (n_items < phase_goal) begin
        case ($urandom_range(9))
          0, 1, 2, 3, 4: conn_flow(1'b1, 2'($urandom_range(3)));
          5, 6: data_flow(1'b1, 2'($urandom_range(3)));
          7: begin
            // hold the sender until the table is quiet
            push_drain();
            conn_flow(1'b1, 2'($urandom_range(3)));
          end
          default: begin
            repeat ($urandom_range(1, 4))
              push_req(op_e'(2'($urandom_range(3))), $urandom, $urandom, 16'($urandom),
                       16'($urandom), 1'($urandom_range(1)), 4'($urandom_range(15)),
                       16'($urandom));
          end
        endcase
      end
      gen_calm = 1'b0;
    end

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    wait (stim_q.size() == 0 && !start_i && !cfg_valid_i && expected_q.size() == 0);
    repeat (20) @(posedge clk_i);
    if (expected_q.size() != 0) n_fail++;
    $display("covered %0d verdicts, %0d inserts (%0d refused as full), %0d proxy sets",
             n_verdict, n_insert, n_full, n_proxy);
    $display("checked %0d results (%0d accepted), %0d register writes, %0d failures",
             n_checked, n_accepted, n_cfg, n_fail);
    if (n_fail == 0) begin
      $display("tcp_connection_tracking_table_top regression: pass");
    end else begin
      $display("tcp_connection_tracking_table_top regression: fail");
    end
    $finish;
  end

endmodule
